// File: hw/rtl/fctg_pkg.sv
// Package with shared widths, register indexes, reset values and types.
`timescale 1ns / 1ps
`default_nettype none
package fctg_pkg;

  localparam int unsigned PixW  = 11;
  localparam int unsigned DimW  = 12;
  localparam int unsigned PosW  = 32;
  localparam int unsigned DirW  = 21;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TexW  = 6;

  // Pipeline arithmetic widths.
  localparam int unsigned ProdW = 34;
  localparam int unsigned SumW  = 35;
  localparam int unsigned NumW  = 48;
  localparam int unsigned MagW  = 44;
  localparam int unsigned DenW  = 24;

  localparam int unsigned TexSizeDefault  = 64;
  localparam int unsigned FracBitsDefault = 16;

  localparam logic [DimW-1:0]        WidthRst  = 12'd640;
  localparam logic [DimW-1:0]        HeightRst = 12'd480;
  localparam logic signed [PosW-1:0] PosRst    = '0;
  localparam logic signed [DirW-1:0] DirLxRst  = 21'sd65536;
  localparam logic signed [DirW-1:0] DirLyRst  = -21'sd65536;
  localparam logic signed [DirW-1:0] DirRxRst  = 21'sd65536;
  localparam logic signed [DirW-1:0] DirRyRst  = 21'sd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_PLAYER_POS_X  = 3'd2,
    CFG_PLAYER_POS_Y  = 3'd3,
    CFG_DIR_LEFT_X    = 3'd4,
    CFG_DIR_LEFT_Y    = 3'd5,
    CFG_DIR_RIGHT_X   = 3'd6,
    CFG_DIR_RIGHT_Y   = 3'd7
  } fctg_cfg_e;

  typedef struct packed {
    logic valid;
    logic covered;
    logic surface;
    logic neg_x;
    logic neg_y;
  } fctg_meta_t;

endpackage
`default_nettype wire

// File: hw/rtl/floor_ceiling_texcoord_generator_unit.sv
// Top level of the floor and ceiling texture coordinate generator.
//
//  channel   | dir | fields (low bit first)
//  s_axis    | in  | tdata: pixel_x[10:0], pixel_y[21:11]
//  m_axis    | out | tdata: tex_u[5:0], tex_v[11:6]; tuser: covered[0], surface[1]
//  cfg       | in  | cfg_index_i selects the register, cfg_data_i holds the value
//
// One pixel is taken every clock while the output is not stalled; its result
// passes through the decode and multiply stages, the divider pipeline
// (one quotient bit per stage), and the output register.
// Reset clears all valid bits and loads the register defaults.
// When the output transfer stalls, every stage holds, so nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module floor_ceiling_texcoord_generator_unit #(
  parameter int unsigned TEX_SIZE  = fctg_pkg::TexSizeDefault,
  parameter int unsigned FRAC_BITS = fctg_pkg::FracBitsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [23:0]                    s_axis_tdata,  // pixel_x, pixel_y
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [15:0]                         m_axis_tdata,  // tex_u, tex_v
  output logic [1:0]                          m_axis_tuser,  // covered, surface
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fctg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [fctg_pkg::CfgDataW-1:0]  cfg_data_i
);
  import fctg_pkg::*;

  localparam int unsigned TexSzW = $clog2(TEX_SIZE) + 1;
  localparam int unsigned TexPW  = FRAC_BITS + TexSzW + TexW;

  logic [DimW-1:0]        width_q, height_q;
  logic signed [PosW-1:0] pos_x_q, pos_y_q;
  logic signed [DirW-1:0] dlx_q, dly_q, drx_q, dry_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      pos_x_q  <= PosRst;
      pos_y_q  <= PosRst;
      dlx_q    <= DirLxRst;
      dly_q    <= DirLyRst;
      drx_q    <= DirRxRst;
      dry_q    <= DirRyRst;
    end else if (cfg_valid_i) begin
      case (fctg_cfg_e'(cfg_index_i))
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i[DimW-1:0];
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i[DimW-1:0];
        CFG_PLAYER_POS_X:  pos_x_q  <= cfg_data_i[PosW-1:0];
        CFG_PLAYER_POS_Y:  pos_y_q  <= cfg_data_i[PosW-1:0];
        CFG_DIR_LEFT_X:    dlx_q    <= cfg_data_i[DirW-1:0];
        CFG_DIR_LEFT_Y:    dly_q    <= cfg_data_i[DirW-1:0];
        CFG_DIR_RIGHT_X:   drx_q    <= cfg_data_i[DirW-1:0];
        CFG_DIR_RIGHT_Y:   dry_q    <= cfg_data_i[DirW-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1: row classification and row distance.
  logic [PixW-1:0] pix_x, pix_y;
  logic [DimW-1:0] half, y_ext;
  logic            ceil_row, floor_row;
  logic [PixW-1:0] dist_d;
  fctg_meta_t      m1_d, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic [PixW-1:0] x1_q, d1_q;

  assign pix_x = s_axis_tdata[PixW-1:0];
  assign pix_y = s_axis_tdata[2*PixW-1:PixW];

  always_comb begin
    half      = height_q >> 1;
    y_ext     = {1'b0, pix_y};
    ceil_row  = (y_ext >= DimW'(1)) && (y_ext < half);
    floor_row = (y_ext > half) && (y_ext < height_q);
    dist_d    = ceil_row ? PixW'(half - y_ext) : PixW'(y_ext - half);
    m1_d         = '0;
    m1_d.valid   = s_axis_tvalid;
    m1_d.covered = ({1'b0, pix_x} < width_q) && (ceil_row || floor_row);
    m1_d.surface = floor_row;
  end

  // Stage 2: products, stage 3: sums, stage 4: times H, stage 5: magnitude.
  logic signed [ProdW-1:0] pax_q, pbx_q, pay_q, pby_q;
  logic [DenW-1:0]         den2_q, den3_q, den4_q, den5_q;
  logic signed [SumW-1:0]  sx_q, sy_q;
  logic signed [NumW-1:0]  nx_q, ny_q;
  logic [MagW-1:0]         mx_q, my_q;
  logic signed [DirW:0]    dfx, dfy;
  logic signed [DimW:0]    w_s, h_s, x_s;
  logic signed [NumW-1:0]  nx_d, ny_d;

  assign dfx = {drx_q[DirW-1], drx_q} - {dlx_q[DirW-1], dlx_q};
  assign dfy = {dry_q[DirW-1], dry_q} - {dly_q[DirW-1], dly_q};
  assign w_s = {1'b0, width_q};
  assign h_s = {1'b0, height_q};
  assign x_s = {2'b00, x1_q};
  assign nx_d = NumW'(sx_q * h_s);
  assign ny_d = NumW'(sy_q * h_s);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q   <= pix_x;
      d1_q   <= dist_d;
      pax_q  <= ProdW'(dlx_q * w_s);
      pbx_q  <= ProdW'(x_s * dfx);
      pay_q  <= ProdW'(dly_q * w_s);
      pby_q  <= ProdW'(x_s * dfy);
      den2_q <= {DenW'(d1_q * width_q) << 1};
      sx_q   <= SumW'(pax_q) + SumW'(pbx_q);
      sy_q   <= SumW'(pay_q) + SumW'(pby_q);
      den3_q <= den2_q;
      nx_q   <= nx_d;
      ny_q   <= ny_d;
      den4_q <= den3_q;
      mx_q   <= nx_q[NumW-1] ? MagW'(-nx_q) : MagW'(nx_q);
      my_q   <= ny_q[NumW-1] ? MagW'(-ny_q) : MagW'(ny_q);
      den5_q <= den4_q;
    end
  end

  fctg_meta_t m5_d;
  always_comb begin
    m5_d       = m4_q;
    m5_d.neg_x = nx_q[NumW-1];
    m5_d.neg_y = ny_q[NumW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
      m2_q <= '0;
      m3_q <= '0;
      m4_q <= '0;
      m5_q <= '0;
    end else if (adv) begin
      m1_q <= m1_d;
      m2_q <= m1_q;
      m3_q <= m2_q;
      m4_q <= m3_q;
      m5_q <= m5_d;
    end
  end

  logic [MagW-1:0] qx, qy;
  logic [DenW-1:0] rx, ry;

  fctg_div_pipe #(.NUM_W(MagW), .DEN_W(DenW)) u_div_x (
    .clk_i, .en_i(adv), .num_i(mx_q), .den_i(den5_q), .quo_o(qx), .rem_o(rx)
  );
  fctg_div_pipe #(.NUM_W(MagW), .DEN_W(DenW)) u_div_y (
    .clk_i, .en_i(adv), .num_i(my_q), .den_i(den5_q), .quo_o(qy), .rem_o(ry)
  );

  fctg_meta_t md_q [MagW];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MagW; i++) md_q[i] <= '0;
    end else if (adv) begin
      md_q[0] <= m5_q;
      for (int i = 1; i < MagW; i++) md_q[i] <= md_q[i-1];
    end
  end

  // Final stage: floor correction, add position, scale fraction to texels.
  fctg_meta_t           mf;
  logic [FRAC_BITS-1:0] offx, offy, wx, wy;
  logic [TexPW-1:0]     px, py;
  logic [TexW-1:0]      tu_d, tv_d;

  always_comb begin
    mf   = md_q[MagW-1];
    offx = mf.neg_x ? (~qx[FRAC_BITS-1:0] + FRAC_BITS'(rx == '0))
                    : qx[FRAC_BITS-1:0];
    offy = mf.neg_y ? (~qy[FRAC_BITS-1:0] + FRAC_BITS'(ry == '0))
                    : qy[FRAC_BITS-1:0];
    wx   = pos_x_q[FRAC_BITS-1:0] + offx;
    wy   = pos_y_q[FRAC_BITS-1:0] + offy;
    px   = TexPW'(wx) * TexPW'(TEX_SIZE);
    py   = TexPW'(wy) * TexPW'(TEX_SIZE);
    tu_d = mf.covered ? px[FRAC_BITS +: TexW] : '0;
    tv_d = mf.covered ? py[FRAC_BITS +: TexW] : '0;
  end

  logic            out_valid_q, cov_q, surf_q;
  logic [TexW-1:0] tu_q, tv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= mf.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cov_q  <= mf.covered;
      surf_q <= mf.covered && mf.surface;
      tu_q   <= tu_d;
      tv_q   <= tv_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, tv_q, tu_q};
  assign m_axis_tuser  = {surf_q, cov_q};

endmodule
`default_nettype wire

// File: hw/rtl/fctg_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
module fctg_div_pipe #(
  parameter int unsigned NUM_W = fctg_pkg::MagW,
  parameter int unsigned DEN_W = fctg_pkg::DenW
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [NUM_W-1:0] quo_o,
  output logic      [DEN_W-1:0] rem_o
);

  logic [NUM_W-1:0] quo_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;
    logic [NUM_W-1:0] quo_d;
    logic [DEN_W-1:0] rem_d;

    if (k == 0) begin : g_first
      assign quo_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      shifted = {rem_in, quo_in[NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_in};
      if (!trial[DEN_W+1]) begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_in[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DEN_W-1:0];
        quo_d = {quo_in[NUM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= quo_d;
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[NUM_W-1];
  assign rem_o = rem_q[NUM_W-1];

endmodule
`default_nettype wire
